/* hdl/psbc_pkg.sv */
// Shared types and constants for the pinned size-budget cache directory.
// Used by pinned_size_budget_cache; depends on nothing else.
`default_nettype none
package psbc_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int KEY_W   = 32;
    localparam int SIZE_W  = 24;
    localparam int REF_W   = 16;
    localparam int HIT_W   = 32;
    localparam int STAMP_W = 32;
    localparam int ACC_W   = SIZE_W + CNT_W;
    localparam int THR_W   = SIZE_W + 1;

    // Divide by five: q = (x * DIV5_MUL) >> DIV5_SH, exact for x below 2**26.
    localparam int DIV5_SH  = 31;
    localparam int DIV5_M_W = 29;
    localparam logic [DIV5_M_W-1:0] DIV5_MUL = 29'h1999999A;
    localparam int PROD_W = SIZE_W + DIV5_M_W;

    localparam logic [SIZE_W-1:0]  BUDGET_RST = 24'h100000;
    localparam logic [STAMP_W-1:0] STAMP_TOP  = '1;
    localparam logic [REF_W-1:0]   REF_MAX    = '1;
    localparam logic [HIT_W-1:0]   HIT_MAX    = '1;

    localparam logic [1:0] REQ_LOCK   = 2'd0;
    localparam logic [1:0] REQ_UNLOCK = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    localparam logic [2:0] ST_HIT        = 3'd0;
    localparam logic [2:0] ST_LOADED     = 3'd1;
    localparam logic [2:0] ST_UNLOCKED   = 3'd2;
    localparam logic [2:0] ST_FLUSHED    = 3'd3;
    localparam logic [2:0] ST_NO_ROOM    = 3'd4;
    localparam logic [2:0] ST_TABLE_FULL = 3'd5;
    localparam logic [2:0] ST_NOT_LOCKED = 3'd6;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SIZE_W-1:0]  bytes;
        logic [REF_W-1:0]   refs;
        logic [HIT_W-1:0]   hits;
        logic [STAMP_W-1:0] stamp;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

endpackage
`default_nettype wire

/* hdl/psbc_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Holds the per-slot entry records; no dependencies.
`default_nettype none
module psbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* hdl/pinned_size_budget_cache.sv */
// Pinned size-budget cache directory: top level with the request sequencer.
// Depends on psbc_pkg and psbc_ram.
// Every lock, unlock or flush request sweeps the 64-slot record RAM once; a missing lock that
// must evict adds one sweep per victim examined, and a stamp wrap adds one sweep per valid
// entry plus one. The result strobe o_valid is high for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) clears valid bits, totals and stamp counter; budget 1 MiB.
`default_nettype none
module pinned_size_budget_cache (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic signed [psbc_pkg::KEY_W-1:0] i_key,
    input  wire logic [psbc_pkg::SIZE_W-1:0]     i_entry_size,
    input  wire logic                            i_cfg_we,
    input  wire logic [psbc_pkg::SIZE_W-1:0]     i_cfg_data,
    output logic                                 o_valid,
    output logic [2:0]                           o_status,
    output logic [psbc_pkg::IDX_W-1:0]           o_slot,
    output logic [psbc_pkg::REF_W-1:0]           o_ref_count,
    output logic [psbc_pkg::SIZE_W-1:0]          o_used_bytes,
    output logic [psbc_pkg::CNT_W-1:0]           o_entry_count,
    output logic [psbc_pkg::CNT_W-1:0]           o_evicted_count
);
    import psbc_pkg::*;

    // The sequencer. Every working state except MUL, THR, FIT and DONE runs one sweep of the
    // record RAM: an address counter issues reads, and the data returns in the next cycle.
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SEARCH = 9'b000000010,
        S_FLUSH  = 9'b000000100,
        S_MUL    = 9'b000001000,
        S_THR    = 9'b000010000,
        S_VPASS  = 9'b000100000,
        S_FIT    = 9'b001000000,
        S_RPASS  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state;

    logic [SIZE_W-1:0]  r_budget;
    logic [1:0]         r_req;
    logic [KEY_W-1:0]   r_key;
    logic [SIZE_W-1:0]  r_size;
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_picked;
    logic [ENTRIES-1:0] r_gath;
    logic [STAMP_W-1:0] r_stamp;
    logic [SIZE_W-1:0]  r_bytes;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_evicted;
    logic [CNT_W-1:0]   r_gcnt;
    logic [CNT_W-1:0]   r_rank;
    logic [ACC_W-1:0]   r_accum;
    logic [THR_W-1:0]   r_thr;
    logic [PROD_W-1:0]  r_prod;
    logic [IDX_W-1:0]   r_free;
    logic [2:0]         r_status;
    logic [IDX_W-1:0]   r_slot;
    logic [REF_W-1:0]   r_refs;

    // Sweep pipeline.
    logic [CNT_W-1:0]   r_idx;
    logic               r_pv;
    logic [IDX_W-1:0]   r_pa;

    // Running best (victim order or stamp order) and key-search match.
    logic               r_bvld;
    logic [IDX_W-1:0]   r_bslot;
    t_rec               r_brec;
    logic               r_found;
    logic [IDX_W-1:0]   r_fslot;
    t_rec               r_frec;

    logic [REC_W-1:0]   ram_rdata;
    t_rec               rd;
    logic               scanning;
    logic               issue;
    logic               last;
    logic               dv;

    always_comb begin
        rd       = t_rec'(ram_rdata);
        scanning = (r_state == S_SEARCH) || (r_state == S_FLUSH) ||
                   (r_state == S_VPASS) || (r_state == S_RPASS);
        issue    = scanning && !r_idx[CNT_W-1];
        last     = r_pv && (r_pa == IDX_W'(ENTRIES - 1));
        dv       = r_pv && r_valid[r_pa];
    end

    // Key search: first valid slot whose key matches.
    logic             match;
    logic             n_found;
    logic [IDX_W-1:0] n_fslot;
    t_rec             n_frec;

    always_comb begin
        match   = dv && (rd.key == r_key) && !r_found;
        n_found = r_found || match;
        n_fslot = match ? r_pa : r_fslot;
        n_frec  = match ? rd : r_frec;
    end

    // Best candidate. Victims: fewest hits, then oldest stamp, then lowest slot, among
    // unreferenced entries not yet taken. Renumbering: oldest stamp, then lowest slot.
    logic             cand;
    logic             better;
    logic             upd;
    logic             n_bvld;
    logic [IDX_W-1:0] n_bslot;
    t_rec             n_brec;

    always_comb begin
        if (r_state == S_VPASS) begin
            cand   = dv && (rd.refs == '0) && !r_picked[r_pa];
            better = !r_bvld || (rd.hits < r_brec.hits) ||
                     ((rd.hits == r_brec.hits) && (rd.stamp < r_brec.stamp));
        end else begin
            cand   = dv && !r_picked[r_pa];
            better = !r_bvld || (rd.stamp < r_brec.stamp);
        end
        upd     = cand && better;
        n_bvld  = r_bvld || upd;
        n_bslot = upd ? r_pa : r_bslot;
        n_brec  = upd ? rd : r_brec;
    end

    // Lowest free slot.
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;

    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_ok  = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Derived values used at the end of sweeps.
    logic [STAMP_W-1:0] nst;
    logic               fits;
    logic [THR_W-1:0]   vb;
    logic [ACC_W-1:0]   vsum;
    t_rec               hit_rec;
    t_rec               unl_rec;
    t_rec               ins_rec;
    t_rec               ren_rec;

    always_comb begin
        nst  = r_stamp + STAMP_W'(1);
        fits = ({1'b0, r_budget} >= ({1'b0, r_bytes} + {1'b0, r_size}));
        vb   = {1'b0, n_brec.bytes};
        vsum = r_accum + ACC_W'(n_brec.bytes);

        hit_rec       = n_frec;
        hit_rec.hits  = (n_frec.hits == HIT_MAX) ? n_frec.hits : n_frec.hits + HIT_W'(1);
        hit_rec.refs  = (n_frec.refs == REF_MAX) ? n_frec.refs : n_frec.refs + REF_W'(1);
        hit_rec.stamp = nst;

        unl_rec      = n_frec;
        unl_rec.refs = n_frec.refs - REF_W'(1);

        ins_rec.key   = r_key;
        ins_rec.bytes = r_size;
        ins_rec.refs  = REF_W'(1);
        ins_rec.hits  = '0;
        ins_rec.stamp = nst;

        ren_rec       = n_brec;
        ren_rec.stamp = STAMP_W'(r_rank);
    end

    // RAM write port: the write lands at the same edge the sequencer moves on.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_rec             ram_wdata;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = n_fslot;
        ram_wdata = hit_rec;
        if ((r_state == S_SEARCH) && last && n_found) begin
            if (r_req == REQ_LOCK) begin
                ram_we = 1'b1;
            end else if (n_frec.refs != '0) begin
                ram_we    = 1'b1;
                ram_wdata = unl_rec;
            end
        end else if ((r_state == S_FIT) && fits) begin
            ram_we    = 1'b1;
            ram_waddr = r_free;
            ram_wdata = ins_rec;
        end else if ((r_state == S_RPASS) && last && n_bvld) begin
            ram_we    = 1'b1;
            ram_waddr = n_bslot;
            ram_wdata = ren_rec;
        end
    end

    psbc_ram #(
        .WIDTH(REC_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(REC_W'(ram_wdata)),
        .i_re   (issue),
        .i_raddr(r_idx[IDX_W-1:0]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_budget  <= BUDGET_RST;
            r_valid   <= '0;
            r_stamp   <= '0;
            r_bytes   <= '0;
            r_count   <= '0;
            r_pv      <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_budget <= i_cfg_data;
            end

            // Sweep pipeline runs by itself; states restart it by clearing r_idx.
            // The running best and match are kept only inside a sweep; the state
            // that ends a sweep decides what carries over.
            r_pv <= issue;
            r_pa <= r_idx[IDX_W-1:0];
            if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (scanning && !last) begin
                r_bvld  <= n_bvld;
                r_bslot <= n_bslot;
                r_brec  <= n_brec;
                r_found <= n_found;
                r_fslot <= n_fslot;
                r_frec  <= n_frec;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req     <= i_req_type;
                        r_key     <= KEY_W'(i_key);
                        r_size    <= i_entry_size;
                        r_evicted <= '0;
                        r_status  <= ST_NOT_LOCKED;
                        r_slot    <= '0;
                        r_refs    <= '0;
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        if (i_req_type == REQ_LOCK || i_req_type == REQ_UNLOCK) begin
                            r_state <= S_SEARCH;
                        end else if (i_req_type == REQ_FLUSH) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end

                S_SEARCH: begin
                    if (last) begin
                        r_free   <= free_idx;
                        r_picked <= '0;
                        r_gath   <= '0;
                        r_gcnt   <= '0;
                        r_accum  <= '0;
                        r_bvld   <= 1'b0;
                        r_rank   <= '0;
                        r_idx    <= '0;
                        r_state  <= S_DONE;
                        if (r_req == REQ_LOCK) begin
                            if (n_found) begin
                                r_stamp  <= nst;
                                r_status <= ST_HIT;
                                r_slot   <= n_fslot;
                                r_refs   <= hit_rec.refs;
                                if (nst == STAMP_TOP) begin
                                    r_state <= S_RPASS;
                                end
                            end else if (!free_ok) begin
                                r_status <= ST_TABLE_FULL;
                            end else if (r_size > r_budget) begin
                                r_status <= ST_NO_ROOM;
                            end else if (fits) begin
                                r_state <= S_FIT;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end else if (n_found && (n_frec.refs != '0)) begin
                            r_status <= ST_UNLOCKED;
                            r_slot   <= n_fslot;
                            r_refs   <= unl_rec.refs;
                        end
                    end
                end

                S_FLUSH: begin
                    if (dv && (rd.refs == '0)) begin
                        r_valid[r_pa] <= 1'b0;
                        r_bytes       <= r_bytes - rd.bytes;
                        r_count       <= r_count - CNT_W'(1);
                        r_evicted     <= r_evicted + CNT_W'(1);
                    end
                    if (last) begin
                        r_status <= ST_FLUSHED;
                        r_state  <= S_DONE;
                    end
                end

                // Threshold is the new size plus a fifth of the bytes now in use.
                S_MUL: begin
                    r_prod  <= PROD_W'(r_bytes) * PROD_W'(DIV5_MUL);
                    r_state <= S_THR;
                end

                S_THR: begin
                    r_thr   <= THR_W'(r_size) + THR_W'(r_prod[PROD_W-1:DIV5_SH]);
                    r_idx   <= '0;
                    r_bvld  <= 1'b0;
                    r_state <= S_VPASS;
                end

                // One sweep per victim in eviction order. A victim at or above the
                // threshold goes alone; otherwise victims gather until they reach it.
                S_VPASS: begin
                    if (last) begin
                        r_idx  <= '0;
                        r_bvld <= 1'b0;
                        if (!n_bvld) begin
                            if (r_accum != '0) begin
                                r_valid   <= r_valid & ~r_gath;
                                r_bytes   <= r_bytes - r_accum[SIZE_W-1:0];
                                r_count   <= r_count - r_gcnt;
                                r_evicted <= r_gcnt;
                            end
                            r_state <= S_FIT;
                        end else begin
                            r_picked[n_bslot] <= 1'b1;
                            if (vb >= r_thr) begin
                                r_valid[n_bslot] <= 1'b0;
                                r_bytes          <= r_bytes - n_brec.bytes;
                                r_count          <= r_count - CNT_W'(1);
                                r_evicted        <= CNT_W'(1);
                                r_state          <= S_FIT;
                            end else begin
                                r_accum         <= vsum;
                                r_gath[n_bslot] <= 1'b1;
                                r_gcnt          <= r_gcnt + CNT_W'(1);
                                if (vsum >= ACC_W'(r_thr)) begin
                                    r_valid <= r_valid & ~r_gath &
                                               ~(ENTRIES'(1) << n_bslot);
                                    r_bytes   <= r_bytes - vsum[SIZE_W-1:0];
                                    r_count   <= r_count - r_gcnt - CNT_W'(1);
                                    r_evicted <= r_gcnt + CNT_W'(1);
                                    r_state   <= S_FIT;
                                end
                            end
                        end
                    end
                end

                S_FIT: begin
                    r_picked <= '0;
                    r_bvld   <= 1'b0;
                    r_rank   <= '0;
                    r_idx    <= '0;
                    r_state  <= S_DONE;
                    if (fits) begin
                        r_valid[r_free] <= 1'b1;
                        r_bytes         <= r_bytes + r_size;
                        r_count         <= r_count + CNT_W'(1);
                        r_stamp         <= nst;
                        r_status        <= ST_LOADED;
                        r_slot          <= r_free;
                        r_refs          <= REF_W'(1);
                        if (nst == STAMP_TOP) begin
                            r_state <= S_RPASS;
                        end
                    end else begin
                        r_status <= ST_NO_ROOM;
                    end
                end

                // Stamp wrap: renumber valid entries oldest first, one per sweep.
                S_RPASS: begin
                    if (last) begin
                        r_idx  <= '0;
                        r_bvld <= 1'b0;
                        if (!n_bvld) begin
                            r_stamp <= STAMP_W'(r_count);
                            r_state <= S_DONE;
                        end else begin
                            r_picked[n_bslot] <= 1'b1;
                            r_rank            <= r_rank + CNT_W'(1);
                        end
                    end
                end

                S_DONE: begin
                    r_state <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_busy          = (r_state != S_IDLE);
        o_valid         = (r_state == S_DONE);
        o_status        = r_status;
        o_slot          = r_slot;
        o_ref_count     = r_refs;
        o_used_bytes    = r_bytes;
        o_entry_count   = r_count;
        o_evicted_count = r_evicted;
    end

endmodule
`default_nettype wire
